// ===== rtl/core/ppurt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppurt_pkg: shared types and constants
// Item and result payloads, register codes, address map and frame timing
// for the tile video unit register port.
// ============================================================================
package ppurt_pkg;

    // frame timing
    localparam logic [9:0] DOTS_PER_LINE   = 10'd341;
    localparam logic [9:0] LINES_PER_FRAME = 10'd262;
    localparam logic [9:0] VISIBLE_LINES   = 10'd240;

    // item kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_HIT   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // video address map
    localparam logic [14:0] PATTERN_TOP  = 15'h1fff;
    localparam logic [14:0] NAME_BASE    = 15'h2000;
    localparam logic [14:0] NAME_TOP     = 15'h2fff;
    localparam logic [14:0] PALETTE_BASE = 15'h3f00;
    localparam logic [14:0] STEP_ROW     = 15'd32;
    localparam logic [14:0] STEP_COL     = 15'd1;

    // control register bits
    localparam int CTRL_INC_BIT = 2;
    localparam int CTRL_NMI_BIT = 7;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] pattern_byte;
        logic [7:0] hit_col;
        logic [7:0] hit_row;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [14:0] video_address;
        logic        nmi_pulse;
        logic        frame_done;
        logic [8:0]  dot_column;
        logic [8:0]  scan_line;
    } t_result;

    // result of one transaction before the memory read returns
    typedef struct packed {
        logic [7:0]  rd;
        logic        rd_from_oam;
        logic [14:0] video_address;
        logic        nmi;
        logic        done;
        logic [8:0]  col;
        logic [8:0]  line;
    } t_stage;

    // memory port requests
    typedef struct packed {
        logic        spr_we;
        logic        spr_re;
        logic [7:0]  spr_addr;
        logic        name_we;
        logic        name_re;
        logic [11:0] name_addr;
        logic        pal_we;
        logic [4:0]  pal_addr;
        logic [7:0]  wdata;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== rtl/core/ppurt_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppurt_chan_if: valid/ready channel
// One transaction moves at a clock edge with valid and ready both high.
// ============================================================================
interface ppurt_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ppurt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppurt_mem: sprite, nametable and palette memories
// Single-port synchronous RAMs, registered read, no reset.
// ============================================================================
module ppurt_mem
    import ppurt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output logic [7:0]    o_spr_q,
    output logic [7:0]    o_name_q
);

    logic [7:0] r_spr  [256];
    logic [7:0] r_name [4096];
    logic [7:0] r_pal  [32];
    logic [7:0] r_spr_q;
    logic [7:0] r_name_q;

    always_ff @(posedge i_clk) begin
        if (i_req.spr_we) begin
            r_spr[i_req.spr_addr] <= i_req.wdata;
        end
        if (i_req.spr_re) begin
            r_spr_q <= r_spr[i_req.spr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.name_we) begin
            r_name[i_req.name_addr] <= i_req.wdata;
        end
        if (i_req.name_re) begin
            r_name_q <= r_name[i_req.name_addr];
        end
    end

    // palette has no read path on this port
    always_ff @(posedge i_clk) begin
        if (i_req.pal_we) begin
            r_pal[i_req.pal_addr] <= i_req.wdata;
        end
    end

    assign o_spr_q  = r_spr_q;
    assign o_name_q = r_name_q;

endmodule
`default_nettype wire

// ===== rtl/core/ppurt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppurt_ctrl: register file and dot timing
// Decodes each transaction, updates the registers and counters, and issues
// memory requests. The read buffer may live in the nametable read register.
// ============================================================================
module ppurt_ctrl
    import ppurt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire logic [7:0] i_name_q,
    output t_mem_req   o_req,
    output t_stage     o_stage
);

    logic [8:0]  r_col, n_col;
    logic [8:0]  r_line, n_line;
    logic        r_vblank, n_vblank;
    logic        r_hit, n_hit;
    logic        r_hit_valid, n_hit_valid;
    logic [15:0] r_hit_pos, n_hit_pos;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_mask, n_mask;
    logic        r_second, n_second;
    logic [7:0]  r_scroll_h, n_scroll_h;
    logic [7:0]  r_scroll_v, n_scroll_v;
    logic [7:0]  r_frame_scroll_v, n_frame_scroll_v;
    logic [14:0] r_vptr, n_vptr;
    logic [7:0]  r_rbuf, n_rbuf;
    logic        r_rbuf_in_q, n_rbuf_in_q;  // buffer value sits in nametable q
    logic [7:0]  r_oam_ptr, n_oam_ptr;

    logic [14:0] ptr_adv;
    logic [7:0]  cur_buf;
    logic [9:0]  col_inc;
    logic [9:0]  line_inc;
    logic [15:0] new_pos;
    logic        nmi;
    logic        done;
    logic [7:0]  rd;
    logic        rd_from_oam;

    assign ptr_adv = r_vptr + (r_ctrl[CTRL_INC_BIT] ? STEP_ROW : STEP_COL);
    assign cur_buf = r_rbuf_in_q ? i_name_q : r_rbuf;
    assign col_inc  = {1'b0, r_col} + 10'd1;
    assign line_inc = {1'b0, r_line} + 10'd1;
    assign new_pos  = {i_item.hit_row, i_item.hit_col};

    always_comb begin
        n_col            = r_col;
        n_line           = r_line;
        n_vblank         = r_vblank;
        n_hit            = r_hit;
        n_hit_valid      = r_hit_valid;
        n_hit_pos        = r_hit_pos;
        n_ctrl           = r_ctrl;
        n_mask           = r_mask;
        n_second         = r_second;
        n_scroll_h       = r_scroll_h;
        n_scroll_v       = r_scroll_v;
        n_frame_scroll_v = r_frame_scroll_v;
        n_vptr           = r_vptr;
        n_rbuf           = r_rbuf;
        n_rbuf_in_q      = r_rbuf_in_q;
        n_oam_ptr        = r_oam_ptr;
        nmi              = 1'b0;
        done             = 1'b0;
        rd               = 8'd0;
        rd_from_oam      = 1'b0;
        o_req            = '0;
        o_req.spr_addr   = r_oam_ptr;
        o_req.name_addr  = r_vptr[11:0];
        o_req.pal_addr   = r_vptr[4:0];
        o_req.wdata      = i_item.write_data;

        if (i_fire) begin
            unique case (i_item.kind)
                KIND_READ: begin
                    case (i_item.reg_index)
                        REG_STATUS: begin
                            rd       = {r_vblank, r_hit, 6'd0};
                            n_vblank = 1'b0;
                            n_second = 1'b0;
                        end
                        REG_OAM_DATA: begin
                            rd_from_oam  = 1'b1;
                            o_req.spr_re = 1'b1;
                        end
                        REG_DATA: begin
                            rd = cur_buf;
                            if (r_vptr <= PATTERN_TOP) begin
                                n_rbuf      = i_item.pattern_byte;
                                n_rbuf_in_q = 1'b0;
                            end else if (r_vptr <= NAME_TOP) begin
                                o_req.name_re = 1'b1;
                                n_rbuf_in_q   = 1'b1;
                            end
                            n_vptr = ptr_adv;
                        end
                        default: ;
                    endcase
                end
                KIND_WRITE: begin
                    case (i_item.reg_index)
                        REG_CTRL:     n_ctrl    = i_item.write_data;
                        REG_MASK:     n_mask    = i_item.write_data;
                        REG_OAM_ADDR: n_oam_ptr = i_item.write_data;
                        REG_OAM_DATA: begin
                            o_req.spr_we = 1'b1;
                            n_oam_ptr    = r_oam_ptr + 8'd1;
                        end
                        REG_SCROLL: begin
                            n_vptr = '0;
                            if (!r_second) begin
                                n_scroll_h = i_item.write_data;
                            end else begin
                                n_scroll_v = i_item.write_data;
                            end
                            n_second = ~r_second;
                        end
                        REG_ADDR: begin
                            n_scroll_h  = 8'd0;
                            n_scroll_v  = 8'd0;
                            n_ctrl[1:0] = 2'b00;
                            if (!r_second) begin
                                n_vptr = {i_item.write_data[6:0], 8'd0};
                            end else begin
                                n_vptr = r_vptr | {7'd0, i_item.write_data};
                            end
                            n_second = ~r_second;
                        end
                        REG_DATA: begin
                            if (r_vptr >= NAME_BASE && r_vptr <= NAME_TOP) begin
                                o_req.name_we = 1'b1;
                            end else if (r_vptr >= PALETTE_BASE) begin
                                o_req.pal_we = 1'b1;
                            end
                            n_vptr = ptr_adv;
                        end
                        default: ;
                    endcase
                end
                KIND_TICK: begin
                    if (r_hit_valid && r_col == {1'b0, r_hit_pos[7:0]}
                            && r_line == {1'b0, r_hit_pos[15:8]}) begin
                        n_hit = 1'b1;
                    end
                    n_col = col_inc[8:0];
                    if (col_inc >= DOTS_PER_LINE) begin
                        n_col  = 9'd0;
                        n_line = line_inc[8:0];
                        if (line_inc == VISIBLE_LINES) begin
                            done     = 1'b1;
                            n_vblank = 1'b1;
                            nmi      = r_ctrl[CTRL_NMI_BIT];
                        end
                        if (line_inc >= LINES_PER_FRAME) begin
                            n_line           = 9'd0;
                            n_vblank         = 1'b0;
                            n_hit            = 1'b0;
                            n_hit_valid      = 1'b0;
                            n_frame_scroll_v = r_scroll_v;
                        end
                    end
                end
                KIND_HIT: begin
                    if (!r_hit_valid || new_pos < r_hit_pos) begin
                        n_hit_pos   = new_pos;
                        n_hit_valid = 1'b1;
                    end
                end
            endcase
        end

        o_stage.rd            = rd;
        o_stage.rd_from_oam   = rd_from_oam;
        o_stage.video_address = n_vptr;
        o_stage.nmi           = nmi;
        o_stage.done          = done;
        o_stage.col           = n_col;
        o_stage.line          = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col            <= '0;
            r_line           <= '0;
            r_vblank         <= 1'b0;
            r_hit            <= 1'b0;
            r_hit_valid      <= 1'b0;
            r_hit_pos        <= '0;
            r_ctrl           <= '0;
            r_mask           <= '0;
            r_second         <= 1'b0;
            r_scroll_h       <= '0;
            r_scroll_v       <= '0;
            r_frame_scroll_v <= '0;
            r_vptr           <= '0;
            r_rbuf           <= '0;
            r_rbuf_in_q      <= 1'b0;
            r_oam_ptr        <= '0;
        end else begin
            r_col            <= n_col;
            r_line           <= n_line;
            r_vblank         <= n_vblank;
            r_hit            <= n_hit;
            r_hit_valid      <= n_hit_valid;
            r_hit_pos        <= n_hit_pos;
            r_ctrl           <= n_ctrl;
            r_mask           <= n_mask;
            r_second         <= n_second;
            r_scroll_h       <= n_scroll_h;
            r_scroll_v       <= n_scroll_v;
            r_frame_scroll_v <= n_frame_scroll_v;
            r_vptr           <= n_vptr;
            r_rbuf           <= n_rbuf;
            r_rbuf_in_q      <= n_rbuf_in_q;
            r_oam_ptr        <= n_oam_ptr;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ppu_register_port_and_timing.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppu_register_port_and_timing: register port and dot timing
// Eight-register host port of a tile video unit with dot/line counter.
// ============================================================================
// One transaction enters per clock and yields exactly one result, in order;
// a result passes through the holding stage and then the output register.
// The holding stage exists because of the registered read of the sprite and
// nametable RAMs: a transaction waits there while its read completes, then
// moves into the output register. The input is ready
// whenever the holding stage is empty or moving on, so the port sustains one
// transaction per clock as long as results are taken. The data port's read
// buffer is forwarded from the nametable read register, so consecutive data
// reads run back to back. Memories are not cleared by reset; reading a
// sprite or nametable entry never written returns an undefined byte.
// Kinds: 0 register read, 1 register write, 2 one dot tick, 3 sprite-0 hit
// report (row, column of the first overlap).
// ============================================================================
module ppu_register_port_and_timing
    import ppurt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    ppurt_chan_if.sink     i_item,
    ppurt_chan_if.source   o_result
);

    t_mem_req req;
    t_stage   stage;
    logic [7:0] spr_q;
    logic [7:0] name_q;
    logic fire;
    logic s1_move;

    // holding stage: waits for the memory read
    logic    r_s1_valid;
    t_stage  r_s1;
    // output register
    logic    r_out_valid;
    t_result r_out;

    assign s1_move      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || s1_move;
    assign fire         = i_item.valid && i_item.ready;

    ppurt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (i_item.payload),
        .i_name_q (name_q),
        .o_req    (req),
        .o_stage  (stage)
    );

    ppurt_mem u_mem (
        .i_clk    (i_clk),
        .i_req    (req),
        .o_spr_q  (spr_q),
        .o_name_q (name_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1 <= stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sprite q is stable while the holding stage waits: no new transaction
    // is taken until it moves
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.read_data     <= r_s1.rd_from_oam ? spr_q : r_s1.rd;
            r_out.video_address <= r_s1.video_address;
            r_out.nmi_pulse     <= r_s1.nmi;
            r_out.frame_done    <= r_s1.done;
            r_out.dot_column    <= r_s1.col;
            r_out.scan_line     <= r_s1.line;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/ppurt_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppurt_chk: port checker
// Watches the result channel of the register port for timing consistency.
// ============================================================================
module ppurt_chk
    import ppurt_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire t_result    i_out
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_nmi_in_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.nmi_pulse |-> i_out.frame_done)
        else $error("nmi pulse without frame done");

    a_done_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.frame_done |->
            i_out.dot_column == 9'd0 && {1'b0, i_out.scan_line} == VISIBLE_LINES)
        else $error("frame done away from vblank entry");

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> {1'b0, i_out.dot_column} < DOTS_PER_LINE
            && {1'b0, i_out.scan_line} < LINES_PER_FRAME)
        else $error("dot or line counter out of range");

endmodule

bind ppu_register_port_and_timing ppurt_chk u_ppurt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out       (o_result.payload)
);
`default_nettype wire
